// ----- rtl/bbc_pkg.sv -----
// Shared types, character codes and helpers for the bracket balance checker.
// Depends on nothing; every other file but bbc_if refers to it by scoped names.
package bbc_pkg;

  // Bracket kinds as kept on the open-bracket stack
  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2
  } kind_t;

  // Error codes, first one sticks until the end of the text
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNMATCHED  = 2'd1;
  localparam logic [1:0] ERR_WRONG_KIND = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW   = 2'd3;

  // Character codes
  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
  localparam logic [7:0] CH_QUOTE        = 8'h22;
  localparam logic [7:0] CH_BACKSLASH    = 8'h5C;

  localparam logic [6:0] DEPTH_SAT = 7'd127;

  // Decoded bracket class of one byte
  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_t kind;
  } class_t;

  // Stack operation requested by the core
  typedef struct packed {
    logic  push;
    logic  pop;
    logic  clear;
    kind_t kind;
  } stack_ctrl_t;

  // Stack status seen by the core
  typedef struct packed {
    logic  empty;
    logic  full;
    kind_t top_kind;
  } stack_stat_t;

  // One result item
  typedef struct packed {
    logic       balanced;
    logic [1:0] error_code;
    logic [6:0] open_depth;
    logic       inside_string;
    logic       text_done;
  } result_t;

  function automatic class_t classify(input logic [7:0] b);
    class_t c;
    c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    case (b)
      CH_OPEN_ROUND:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
      CH_OPEN_SQUARE:  c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
      CH_OPEN_CURLY:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
      CH_CLOSE_ROUND:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
      CH_CLOSE_SQUARE: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
      CH_CLOSE_CURLY:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
      default:         c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/bbc_if.sv -----
// Valid/ready channel interfaces for text bytes in and verdicts out.
// Depends on nothing.
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface bbc_out_if;
  logic       valid;
  logic       ready;
  logic       balanced;
  logic [1:0] error_code;
  logic [6:0] open_depth;
  logic       inside_string;
  logic       text_done;

  modport source (output valid, output balanced, output error_code, output open_depth,
                  output inside_string, output text_done, input ready);
  modport sink (input valid, input balanced, input error_code, input open_depth,
                input inside_string, input text_done, output ready);
endinterface

// ----- rtl/bbc_stack.sv -----
// Open-bracket stack: depth counter, kind memory and a forwarded top entry.
// Depends on bbc_pkg for the control and status structs.
module bbc_stack #(
  parameter int STACK_DEPTH = 64,
  parameter int CW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bbc_pkg::stack_ctrl_t ctrl,
  output bbc_pkg::stack_stat_t stat,
  output logic [CW-1:0]        count
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  bbc_pkg::kind_t mem [STACK_DEPTH];
  bbc_pkg::kind_t rd_data;
  bbc_pkg::kind_t fwd_kind;
  logic           fwd;
  logic [CW-1:0]  count_next;
  logic [CW-1:0]  top_next;
  logic [AW-1:0]  rd_addr;

  // Compute the depth after this cycle's operation
  always_comb begin
    if (ctrl.clear) begin
      count_next = '0;
    end else if (ctrl.push) begin
      count_next = count + CW'(1);
    end else if (ctrl.pop) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
    top_next = count_next - CW'(1);
    rd_addr  = top_next[AW-1:0];
  end

  // Advance the depth counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      fwd   <= 1'b0;
    end else begin
      count <= count_next;
      fwd   <= ctrl.push;
    end
  end

  // Write the pushed kind, prefetch the entry that will be on top
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[count[AW-1:0]] <= ctrl.kind;
    end
    rd_data  <= mem[rd_addr];
    fwd_kind <= ctrl.kind;
  end

  // A push in the last cycle wrote the top entry: take it from the bypass
  assign stat.top_kind = fwd ? fwd_kind : rd_data;
  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CW'(STACK_DEPTH));

endmodule

// ----- rtl/bbc_core.sv -----
// Per-byte checker logic: string and escape flags, sticky error, stack requests
// and the result of each item. Depends on bbc_pkg.
module bbc_core #(
  parameter int CW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_text,
  input  bbc_pkg::stack_stat_t stat,
  input  logic [CW-1:0]        count,
  output bbc_pkg::stack_ctrl_t ctrl,
  output bbc_pkg::result_t     res
);

  logic           in_quote;
  logic           escape_pending;
  logic [1:0]     sticky_error;
  logic           in_quote_next;
  logic           escape_pending_next;
  logic [1:0]     sticky_error_next;
  bbc_pkg::class_t cls;
  logic [CW-1:0]  depth_after;
  logic [31:0]    depth_ext;

  assign cls = bbc_pkg::classify(text_byte);

  // Decide the effect of the byte
  always_comb begin
    in_quote_next       = in_quote;
    escape_pending_next = escape_pending;
    sticky_error_next   = sticky_error;
    ctrl.push           = 1'b0;
    ctrl.pop            = 1'b0;
    ctrl.kind           = cls.kind;
    if (accept && sticky_error == bbc_pkg::ERR_NONE) begin
      if (in_quote) begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
        end else if (text_byte == bbc_pkg::CH_BACKSLASH) begin
          escape_pending_next = 1'b1;
        end else if (text_byte == bbc_pkg::CH_QUOTE) begin
          in_quote_next = 1'b0;
        end
      end else if (text_byte == bbc_pkg::CH_QUOTE) begin
        in_quote_next = 1'b1;
      end else if (cls.is_open) begin
        if (stat.full) begin
          sticky_error_next = bbc_pkg::ERR_OVERFLOW;
        end else begin
          ctrl.push = 1'b1;
        end
      end else if (cls.is_close) begin
        if (stat.empty) begin
          sticky_error_next = bbc_pkg::ERR_UNMATCHED;
        end else if (stat.top_kind != cls.kind) begin
          sticky_error_next = bbc_pkg::ERR_WRONG_KIND;
        end else begin
          ctrl.pop = 1'b1;
        end
      end
    end
    ctrl.clear = accept && end_of_text;
  end

  // Build the verdict from the state after the byte, before any clear
  always_comb begin
    if (ctrl.push) begin
      depth_after = count + CW'(1);
    end else if (ctrl.pop) begin
      depth_after = count - CW'(1);
    end else begin
      depth_after = count;
    end
    depth_ext         = 32'(depth_after);
    res.open_depth    = (depth_ext > 32'd127) ? bbc_pkg::DEPTH_SAT : depth_ext[6:0];
    res.error_code    = sticky_error_next;
    res.inside_string = in_quote_next;
    res.text_done     = end_of_text;
    res.balanced      = (sticky_error_next == bbc_pkg::ERR_NONE) && !in_quote_next
                        && (depth_after == '0);
  end

  // Update flags; the last byte of a text clears them
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      in_quote       <= 1'b0;
      escape_pending <= 1'b0;
      sticky_error   <= bbc_pkg::ERR_NONE;
    end else begin
      in_quote       <= in_quote_next;
      escape_pending <= escape_pending_next;
      sticky_error   <= sticky_error_next;
    end
  end

endmodule

// ----- rtl/bbc_out_buf.sv -----
// Result register with one skid entry so input and output stalls are decoupled.
// Depends on bbc_pkg for the result struct.
module bbc_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  bbc_pkg::result_t wr_data,
  output logic             wr_ready,
  output logic             valid,
  input  logic             ready,
  output bbc_pkg::result_t data
);

  logic             skid_valid;
  bbc_pkg::result_t skid_data;

  assign wr_ready = !skid_valid;

  // Control: main register drains first, skid catches an item during a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!valid || ready) begin
      if (skid_valid) begin
        valid      <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        valid <= wr;
      end
    end else if (wr) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (!valid || ready) begin
      if (skid_valid) begin
        data <= skid_data;
      end else if (wr) begin
        data <= wr_data;
      end
    end else if (wr) begin
      skid_data <= wr_data;
    end
  end

endmodule

// ----- rtl/bracket_balance_checker.sv -----
// Top level of the streaming bracket balance checker.
// Depends on bbc_pkg, bbc_if, bbc_stack, bbc_core and bbc_out_buf.
//
// Usage:
//   text carries one text byte per item plus end_of_text on the last byte.
//   verdict carries one result per input item: balanced, error_code,
//   open_depth, inside_string and text_done (a copy of end_of_text).
//   Round, square and curly brackets must nest; bytes inside double-quoted
//   strings are skipped and a backslash in a string escapes the next byte.
//   The first error sticks until the end of the text; the end_of_text item
//   reports the verdict for the whole text and then clears all state.
// Result path: each result is registered in the result buffer, or in its skid entry during a stall.
// Throughput: one byte per cycle while text.ready is high; the stack keeps its top entry in a
//   prefetch register with a bypass, so a push or pop every cycle is taken.
// Reset (rst, synchronous): clears depth, string, escape and error state and
//   empties the result buffer; the kind memory itself is not cleared.
// Stall: the result register plus a one-entry skid buffer keep text ready while the skid entry
//   is empty; text.ready drops once both are full.
module bracket_balance_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  bbc_in_if.sink       text,
  bbc_out_if.source    verdict
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic                 accept;
  logic                 buf_ready;
  bbc_pkg::stack_ctrl_t ctrl;
  bbc_pkg::stack_stat_t stat;
  logic [CW-1:0]        count;
  bbc_pkg::result_t     res;
  bbc_pkg::result_t     out_data;

  assign text.ready = buf_ready;
  assign accept     = text.valid && buf_ready;

  bbc_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .CW          (CW)
  ) u_stack (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .stat  (stat),
    .count (count)
  );

  bbc_core #(
    .CW (CW)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_byte   (text.text_byte),
    .end_of_text (text.end_of_text),
    .stat        (stat),
    .count       (count),
    .ctrl        (ctrl),
    .res         (res)
  );

  bbc_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .wr       (accept),
    .wr_data  (res),
    .wr_ready (buf_ready),
    .valid    (verdict.valid),
    .ready    (verdict.ready),
    .data     (out_data)
  );

  // Drive the result fields
  assign verdict.balanced      = out_data.balanced;
  assign verdict.error_code    = out_data.error_code;
  assign verdict.open_depth    = out_data.open_depth;
  assign verdict.inside_string = out_data.inside_string;
  assign verdict.text_done     = out_data.text_done;

endmodule

// ----- rtl/bbc_checker.sv -----
// Port-level assertions for the bracket balance checker, bound to the top level.
// Depends on bracket_balance_checker and bbc_pkg.
module bbc_checker #(
  parameter int STACK_DEPTH = 64
) (
  input logic       clk,
  input logic       rst,
  input logic       text_ready,
  input logic       verdict_valid,
  input logic       verdict_ready,
  input logic       balanced,
  input logic [1:0] error_code,
  input logic [6:0] open_depth,
  input logic       inside_string
);

  localparam logic [6:0] FULL_DEPTH = (STACK_DEPTH > 127) ? 7'd127 : 7'(STACK_DEPTH);

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && !verdict_ready |=> verdict_valid)
    else $error("result dropped while stalled");

  // Balanced means no error, no open string and no open bracket
  a_balanced: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && balanced |-> error_code == bbc_pkg::ERR_NONE && !inside_string
                                  && open_depth == 7'd0)
    else $error("balanced verdict inconsistent");

  // With no result pending the skid entry is empty and input is taken
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !verdict_valid |-> text_ready)
    else $error("input stalled with empty output");

  // Overflow is only reported with a full stack
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && error_code == bbc_pkg::ERR_OVERFLOW |-> open_depth == FULL_DEPTH)
    else $error("overflow reported below full depth");

endmodule

bind bracket_balance_checker bbc_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_bbc_checker (
  .clk           (clk),
  .rst           (rst),
  .text_ready    (text.ready),
  .verdict_valid (verdict.valid),
  .verdict_ready (verdict.ready),
  .balanced      (verdict.balanced),
  .error_code    (verdict.error_code),
  .open_depth    (verdict.open_depth),
  .inside_string (verdict.inside_string)
);
